>>> design/arc_pkg.sv
// Shared constants and types for the alarm relay channel.
package arc_pkg;

    localparam int SENSORS    = 16;
    localparam int MASK_W     = 16;
    localparam int CODE_W     = 3;
    localparam int STATES_W   = SENSORS * CODE_W;
    localparam int COUNT_W    = 5;
    localparam int SUM_W      = 7;
    localparam int SUM_ACC_W  = 8;
    localparam int DELAY_W    = 8;
    localparam int KIND_W     = 2;
    localparam int LANES      = (SENSORS < MASK_W) ? SENSORS : MASK_W;
    localparam int GROUPS     = (LANES + 3) / 4;

    // Stream payload widths (padded to whole bytes).
    localparam int IN_TDATA_W  = ((STATES_W + 2 + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 16;

    // Configuration port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [CODE_W-1:0]    FAULT_CODE = 3'd2;
    localparam logic [SUM_ACC_W-1:0] SUM_MAX    = 8'd127;

    typedef enum logic [KIND_W-1:0] {
        KIND_PLAIN = 2'd0,
        KIND_SOUND = 2'd1,
        KIND_LIGHT = 2'd2,
        KIND_SPARE = 2'd3
    } t_relay_kind;

    typedef enum logic [2:0] {
        REG_LEVEL_LO  = 3'd0,
        REG_LEVEL_HI  = 3'd1,
        REG_MIN_COUNT = 3'd2,
        REG_DELAY_LIM = 3'd3,
        REG_KIND      = 3'd4
    } t_reg_index;

endpackage

>>> design/alarm_relay_channel.sv
// Alarm relay channel: per-scan sensor qualification, trip delay, silence and lamp test.
//
//  channel   direction  accept condition              payload
//  s_axis    in         s_axis_tvalid & s_axis_tready  one scan: sensor states, buttons
//  m_axis    out        m_axis_tvalid & m_axis_tready  one result per scan
//  apb       in/out     psel & penable & pwrite        config register write
//
// One scan per cycle sustained while m_axis_tready is high; an accepted scan passes from the
// input register to the result register through the qualify/count/sum/trip logic.
// i_rst_n is synchronous: clears valids, trip delay, acknowledged severity and config.
// A stalled result holds the result register; the input register still takes one more
// scan, and s_axis_tready drops only when both registers are full.
module alarm_relay_channel (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // scan input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [47:0] sensor_states, [48] lamp_test, [49] silence_button, [55:50] zero
    input  logic [arc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] relay_on, [5:1] qualifying_count, [12:6] severity_sum, [15:13] zero
    output logic [arc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [arc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [arc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [arc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import arc_pkg::*;

    // configuration registers
    logic [MASK_W-1:0]  r_level_lo;
    logic [MASK_W-1:0]  r_level_hi;
    logic [COUNT_W-1:0] r_min_count;
    logic [DELAY_W-1:0] r_delay_limit;
    t_relay_kind        r_kind;

    // channel state
    logic [DELAY_W-1:0] r_delay_count, n_delay_count;
    logic [SUM_W-1:0]   r_ack_sev, n_ack_sev;

    // input register
    logic                r_in_valid;
    logic [STATES_W-1:0] r_states;
    logic                r_check;
    logic                r_silence;

    // result register
    logic               r_out_valid;
    logic               r_relay_on, n_relay_on;
    logic [COUNT_W-1:0] r_count;
    logic [SUM_W-1:0]   r_sum;

    logic               in_acc;
    logic               adv;
    logic               cfg_wr;
    t_reg_index         cfg_idx;

    logic [GROUPS*4-1:0]       lane_qual;
    logic [CODE_W-1:0]         lane_code [GROUPS*4];
    logic [COUNT_W-1:0]        grp_count [GROUPS];
    logic [SUM_ACC_W-1:0]      grp_sum   [GROUPS];
    logic [COUNT_W-1:0]        count;
    logic [SUM_ACC_W-1:0]      sum_acc;
    logic [SUM_W-1:0]          sum;
    logic                      trip;

    // ---------------- handshake ----------------
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 1 - COUNT_W - SUM_W){1'b0}},
                            r_sum, r_count, r_relay_on};

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_index'(paddr[APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_LEVEL_LO:  prdata = {{(APB_DATA_W - MASK_W){1'b0}}, r_level_lo};
            REG_LEVEL_HI:  prdata = {{(APB_DATA_W - MASK_W){1'b0}}, r_level_hi};
            REG_MIN_COUNT: prdata = {{(APB_DATA_W - COUNT_W){1'b0}}, r_min_count};
            REG_DELAY_LIM: prdata = {{(APB_DATA_W - DELAY_W){1'b0}}, r_delay_limit};
            REG_KIND:      prdata = {{(APB_DATA_W - KIND_W){1'b0}}, r_kind};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_lo    <= '0;
            r_level_hi    <= '0;
            r_min_count   <= COUNT_W'(1);
            r_delay_limit <= '0;
            r_kind        <= KIND_PLAIN;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LEVEL_LO:  r_level_lo    <= pwdata[MASK_W-1:0];
                REG_LEVEL_HI:  r_level_hi    <= pwdata[MASK_W-1:0];
                REG_MIN_COUNT: r_min_count   <= pwdata[COUNT_W-1:0];
                REG_DELAY_LIM: r_delay_limit <= pwdata[DELAY_W-1:0];
                REG_KIND:      r_kind        <= t_relay_kind'(pwdata[KIND_W-1:0]);
                default:       ;
            endcase
        end
    end

    // ---------------- per-sensor qualification ----------------
    always_comb begin
        for (int j = 0; j < GROUPS*4; j++) begin
            lane_qual[j] = 1'b0;
            lane_code[j] = '0;
            if (j < LANES) begin
                lane_code[j] = r_states[CODE_W*j +: CODE_W];
                // level L qualifies codes >= L + fault code; level zero ignores the sensor
                lane_qual[j] = ({r_level_hi[j], r_level_lo[j]} != 2'd0) &&
                               ({1'b0, lane_code[j]} >=
                                ({2'b00, r_level_hi[j], r_level_lo[j]} + {1'b0, FAULT_CODE}));
            end
        end
    end

    // two-level adder tree: groups of four, then the group totals
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_count[g] = '0;
            grp_sum[g]   = '0;
            for (int k = 0; k < 4; k++) begin
                if (lane_qual[4*g + k]) begin
                    grp_count[g] = grp_count[g] + COUNT_W'(1);
                    grp_sum[g]   = grp_sum[g] + SUM_ACC_W'(lane_code[4*g + k]);
                end
            end
        end
        count   = '0;
        sum_acc = '0;
        for (int g = 0; g < GROUPS; g++) begin
            count   = count + grp_count[g];
            sum_acc = sum_acc + grp_sum[g];
        end
        sum = (sum_acc > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sum_acc[SUM_W-1:0];
    end

    // ---------------- trip, delay and silence ----------------
    assign trip = (count >= r_min_count);

    always_comb begin
        n_delay_count = r_delay_count;
        n_ack_sev     = r_ack_sev;
        n_relay_on    = 1'b0;
        if (trip) begin
            if (sum > r_ack_sev) begin
                n_ack_sev = '0;
                if (r_delay_count >= r_delay_limit) begin
                    if (r_kind == KIND_SOUND && r_silence) begin
                        // silence: remember the severity, restart the delay
                        n_ack_sev     = sum;
                        n_delay_count = '0;
                    end else begin
                        n_relay_on = 1'b1;
                    end
                end else begin
                    n_delay_count = r_delay_count + DELAY_W'(1);
                end
            end else begin
                n_delay_count = '0;
            end
        end else begin
            n_delay_count = '0;
            n_ack_sev     = '0;
        end
        if (r_kind == KIND_LIGHT && r_check) begin
            n_relay_on = 1'b1;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_delay_count <= '0;
            r_ack_sev     <= '0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid   <= 1'b1;
                r_delay_count <= n_delay_count;
                r_ack_sev     <= n_ack_sev;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_states  <= s_axis_tdata[STATES_W-1:0];
            r_check   <= s_axis_tdata[STATES_W];
            r_silence <= s_axis_tdata[STATES_W+1];
        end
        if (adv) begin
            r_relay_on <= n_relay_on;
            r_count    <= count;
            r_sum      <= sum;
        end
    end

    // ---------------- assertions ----------------
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled while a register was free");

    a_no_trip_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !trip) |=> (r_delay_count == '0 && r_ack_sev == '0))
        else $error("delay or acknowledge not cleared without trip");

    a_sum_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_count == '0) == (r_sum == '0)))
        else $error("severity sum inconsistent with qualifying count");

    a_silenced_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_kind == KIND_SOUND && n_ack_sev != '0) |=> !r_relay_on)
        else $error("sound relay on while silenced");

endmodule
